### design/ffpea_pkg.sv
// Package for the first-fit page extent allocator.
// Holds the opcode and status codes and the request/response types; no dependencies.
`default_nettype none
package ffpea_pkg;
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_NO_SPACE   = 2'd1;
    localparam logic [1:0] ST_TABLE_FULL = 2'd2;

    typedef struct packed {
        logic [63:0] size;
        logic [63:0] addr;
        logic        list_select;
        logic        op;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [63:0] result_addr;
    } rsp_t;
endpackage
`default_nettype wire

### design/ffpea_mem.sv
// Extent store for the allocator: one synchronous RAM of {start, length} pairs.
// One write port and one read port, read data registered; uses no package.
`default_nettype none
module ffpea_mem #(
    parameter int DEPTH = 32,
    parameter int AW    = 5
) (
    input  wire logic          aclk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire logic [127:0]  wdata,
    input  wire logic [AW-1:0] raddr,
    output logic      [127:0]  rdata
);
    logic [127:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

### design/first_fit_page_extent_allocator.sv
// First-fit page extent allocator, top level with the search sequencer.
// A request walks the extents of its list in order until a hit or a join, or misses past all of
// them; a free that joins none inserts a new extent in front, shifting the others up, and an
// exact fit removes its extent, shifting the rest down. A page size that is not a power of two
// adds a remainder walk first. One request is in flight; the next is taken in the cycle after
// its result is posted, even while that result waits. Reset clears counts, not the RAM.
`default_nettype none
module first_fit_page_extent_allocator #(
    parameter int EXTENTS_PER_LIST = 16,
    parameter int PAGE_BYTES       = 4096,
    parameter int LIST_COUNT       = 2
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // s_tdata fields from bit 0: op, list_select, addr[63:0], size[63:0], zero fill
    input  wire logic [135:0] s_tdata,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // m_tdata fields from bit 0: result_addr[63:0], status[1:0], zero fill
    output logic      [71:0]  m_tdata
);
    localparam int CW    = $clog2(EXTENTS_PER_LIST + 1);
    localparam int LW    = (LIST_COUNT > 1) ? $clog2(LIST_COUNT) : 1;
    localparam int DEPTH = EXTENTS_PER_LIST * LIST_COUNT;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [63:0] PAGE = 64'(PAGE_BYTES);
    localparam logic [63:0] PMASK = PAGE - 64'd1;
    localparam bit POW2 = (PAGE_BYTES & (PAGE_BYTES - 1)) == 0;

    // Reciprocal of the page size for exact quotients of 32-bit values.
    localparam int PL = (PAGE_BYTES > 1) ? $clog2(PAGE_BYTES) : 0;
    localparam int RS = 32 + PL;
    localparam logic [63:0] RM64 = ((64'd1 << RS) + PAGE - 64'd1) / PAGE;
    localparam logic [32:0] RM = RM64[32:0];
    localparam logic [31:0] PAGE32 = PAGE[31:0];

    localparam logic [2:0] S_IDLE = 3'd0, S_RND = 3'd1, S_RD = 3'd2, S_CHK = 3'd3,
                           S_SRD = 3'd4, S_SWR = 3'd5, S_OUT = 3'd6, S_REM = 3'd7;

    logic [2:0]     state_reg;
    ffpea_pkg::req_t req_reg;
    logic [LW-1:0]  tab_reg;
    logic [63:0]    sz_reg;
    logic [63:0]    rem_reg;
    logic [CW-1:0]  idx_reg;
    logic [CW-1:0]  n_reg;
    logic [CW-1:0]  cnt_reg [LIST_COUNT];
    logic           dir_reg;   // 1: shift down (remove), 0: shift up (insert)
    logic [CW-1:0]  stop_reg;
    ffpea_pkg::rsp_t rsp_reg;
    ffpea_pkg::rsp_t out_reg;
    logic           mv_reg;
    logic           out_load;

    // Remainder walk for a page size that is not a power of two: the size is taken
    // in 12-bit slices from the top, and each step reduces {remainder, slice}.
    logic [19:0]    racc_reg;
    logic [31:0]    rq_reg;
    logic [2:0]     rk_reg;
    logic           rph_reg;
    logic [71:0]    size_pad;
    logic [31:0]    ry;
    logic [64:0]    rprod;

    logic           we;
    logic [AW-1:0]  waddr, raddr;
    logic [127:0]   wdata, rdata;
    logic [63:0]    r_start, r_len;

    ffpea_mem #(.DEPTH(DEPTH), .AW(AW)) u_mem (
        .aclk(aclk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
    );
    assign r_start = rdata[127:64];
    assign r_len   = rdata[63:0];

    function automatic logic [AW-1:0] ea(input logic [LW-1:0] t, input logic [CW-1:0] i);
        return AW'(32'(t) * EXTENTS_PER_LIST + 32'(i));
    endfunction

    assign size_pad = {8'd0, req_reg.size};
    assign ry       = {racc_reg, size_pad[rk_reg * 7'd12 +: 12]};
    assign rprod    = {33'd0, ry} * {32'd0, RM};

    // Remainder of the size by the page.
    logic [63:0] size_rem;
    assign size_rem = POW2 ? (req_reg.size & PMASK) : {44'd0, racc_reg};

    // The output register holds the posted result, so the input side is free
    // again as soon as the sequencer is idle.
    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = mv_reg;
    assign m_tdata  = {6'd0, out_reg.status, out_reg.result_addr};
    assign out_load = (state_reg == S_OUT) && (!mv_reg || m_tready);

    logic [63:0] add_amt;
    logic        fit, adj_lo, adj_hi;
    assign add_amt = PAGE - rem_reg;
    assign fit    = r_len >= sz_reg;
    assign adj_lo = (r_start + r_len) == req_reg.addr;
    assign adj_hi = (req_reg.addr + sz_reg) == r_start;

    always_comb begin
        we = 1'b0;
        waddr = ea(tab_reg, idx_reg);
        wdata = {r_start, r_len};
        raddr = ea(tab_reg, idx_reg);
        case (state_reg)
            S_CHK:  begin
                if (req_reg.op == ffpea_pkg::OP_ALLOC) begin
                    if (fit) begin
                        if (r_len != sz_reg) begin
                            we = 1'b1;
                            wdata = {r_start, r_len - sz_reg};
                        end
                    end
                end else if (adj_lo) begin
                    we = 1'b1;
                    wdata = {r_start, r_len + sz_reg};
                end else if (adj_hi) begin
                    we = 1'b1;
                    wdata = {req_reg.addr, r_len + sz_reg};
                end
            end
            S_SRD:  raddr = dir_reg ? ea(tab_reg, idx_reg + CW'(1)) : ea(tab_reg, idx_reg - CW'(1));
            S_SWR:  begin
                we = 1'b1;
                if (!dir_reg && idx_reg == '0) wdata = {req_reg.addr, sz_reg};
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            mv_reg <= 1'b0;
            for (int i = 0; i < LIST_COUNT; i++) cnt_reg[i] <= '0;
        end else begin
            if (out_load) begin
                mv_reg  <= 1'b1;
                out_reg <= rsp_reg;
            end else if (m_tready) begin
                mv_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: if (s_tvalid && s_tready) begin
                    req_reg <= s_tdata[129:0];
                    tab_reg <= LW'(32'(s_tdata[1]) % LIST_COUNT);
                    racc_reg <= '0;
                    rk_reg <= 3'd5;
                    rph_reg <= 1'b0;
                    state_reg <= POW2 ? S_RND : S_REM;
                end
                S_REM: begin
                    // First half of a step forms the quotient, second half the remainder.
                    if (!rph_reg) begin
                        rq_reg <= 32'(rprod >> RS);
                        rph_reg <= 1'b1;
                    end else begin
                        racc_reg <= 20'(ry - rq_reg * PAGE32);
                        rph_reg <= 1'b0;
                        rk_reg <= rk_reg - 3'd1;
                        if (rk_reg == 3'd0) state_reg <= S_RND;
                    end
                end
                S_RND: begin
                    rem_reg <= size_rem;
                    n_reg   <= cnt_reg[tab_reg];
                    idx_reg <= '0;
                    sz_reg  <= req_reg.size - size_rem;
                    rsp_reg <= '{status: ffpea_pkg::ST_OK, result_addr: 64'd0};
                    state_reg <= S_RD;
                end
                S_RD: begin
                    // Round-up fix for allocate on the first pass.
                    if (idx_reg == '0 && req_reg.op == ffpea_pkg::OP_ALLOC && rem_reg != 0) begin
                        if (req_reg.size > ~add_amt) begin
                            rsp_reg.status <= ffpea_pkg::ST_NO_SPACE;
                            state_reg <= S_OUT;
                        end else begin
                            sz_reg <= req_reg.size + add_amt;
                            state_reg <= (n_reg == 0) ? S_OUT : S_CHK;
                            if (n_reg == 0) rsp_reg.status <= ffpea_pkg::ST_NO_SPACE;
                        end
                    end else if (idx_reg >= n_reg) begin
                        if (req_reg.op == ffpea_pkg::OP_ALLOC) begin
                            rsp_reg.status <= ffpea_pkg::ST_NO_SPACE;
                            state_reg <= S_OUT;
                        end else if (n_reg >= CW'(EXTENTS_PER_LIST)) begin
                            rsp_reg.status <= ffpea_pkg::ST_TABLE_FULL;
                            state_reg <= S_OUT;
                        end else begin
                            cnt_reg[tab_reg] <= n_reg + CW'(1);
                            dir_reg <= 1'b0;
                            idx_reg <= n_reg;
                            state_reg <= (n_reg == 0) ? S_SWR : S_SRD;
                        end
                    end else begin
                        state_reg <= S_CHK;
                    end
                end
                S_CHK: begin
                    if (req_reg.op == ffpea_pkg::OP_ALLOC) begin
                        if (fit) begin
                            if (r_len == sz_reg) begin
                                rsp_reg.result_addr <= r_start;
                                cnt_reg[tab_reg] <= n_reg - CW'(1);
                                dir_reg <= 1'b1;
                                stop_reg <= n_reg - CW'(1);
                                state_reg <= (idx_reg + CW'(1) >= n_reg) ? S_OUT : S_SRD;
                            end else begin
                                rsp_reg.result_addr <= r_start + (r_len - sz_reg);
                                state_reg <= S_OUT;
                            end
                        end else begin
                            idx_reg <= idx_reg + CW'(1);
                            state_reg <= S_RD;
                        end
                    end else if (adj_lo || adj_hi) begin
                        state_reg <= S_OUT;
                    end else begin
                        idx_reg <= idx_reg + CW'(1);
                        state_reg <= S_RD;
                    end
                end
                S_SRD: state_reg <= S_SWR;
                S_SWR: begin
                    if (dir_reg) begin
                        idx_reg <= idx_reg + CW'(1);
                        state_reg <= (idx_reg + CW'(1) >= stop_reg) ? S_OUT : S_SRD;
                    end else if (idx_reg == '0) begin
                        state_reg <= S_OUT;
                    end else begin
                        idx_reg <= idx_reg - CW'(1);
                        state_reg <= (idx_reg == CW'(1)) ? S_SWR : S_SRD;
                    end
                end
                S_OUT: if (out_load) begin
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTH
    a_one_out: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_OUT && !mv_reg) |=> mv_reg && state_reg == S_IDLE)
        else $error("result not posted");
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != S_IDLE) |-> !s_tready)
        else $error("accept while busy");
    a_hold_out: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while waiting");
    a_ok_on_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && out_reg.status == ffpea_pkg::ST_TABLE_FULL) |-> out_reg.result_addr == 64'd0)
        else $error("address on table full");
`endif
endmodule
`default_nettype wire
